### hw/rtl/srp_pkg.sv
`timescale 1ns / 1ps
package srp_pkg;

    typedef enum logic [1:0] {
        REQ_RECT  = 2'd0,
        REQ_BIN   = 2'd1,
        REQ_RUN   = 2'd2,
        REQ_CLEAR = 2'd3
    } req_t;

    localparam logic [1:0] KIND_PLACED   = 2'd0;
    localparam logic [1:0] KIND_UNPLACED = 2'd1;
    localparam logic [1:0] KIND_NONE     = 2'd2;

    localparam logic CFG_SPACING = 1'b0;
    localparam logic CFG_TRIM    = 1'b1;

    localparam int RDEF_W  = 6;
    localparam int RCOPY_W = 6;
    localparam int BDEF_W  = 4;
    localparam int BCOPY_W = 4;
    localparam int BKIND_W = 2;
    localparam int COPIES_W = 7;
    localparam int RID_W = RDEF_W + RCOPY_W;
    localparam int BID_W = BKIND_W + BDEF_W + BCOPY_W;

    typedef struct packed {
        logic capture;
        logic mul_start;
        logic ins_begin;
        logic ins_read;
        logic ins_shift;
        logic ins_write;
        logic ins_drop;
        logic def_inc;
        logic clear_all;
        logic run_init;
        logic bin_read;
        logic bin_load;
        logic bin_next;
        logic rect_read;
        logic q_inc;
        logic new_row;
        logic place;
        logic emit_none;
        logic unp_init;
        logic emit_unplaced;
        logic flush;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic mul_busy;
        logic copies_done;
        logic store_full;
        logic i_zero;
        logic shift_cond;
        logic n_zero;
        logic bins_done;
        logic q_done;
        logic placed_q;
        logic fit_x;
        logic fit_y;
        logic row_has;
        logic slot_ok;
        logic out_free;
    } status_t;

endpackage

### hw/rtl/shelf_rectangle_packer.sv
`timescale 1ns / 1ps
// Load rectangle: each stored copy is inserted in order, walking back through the stored entries;
// a copy that finds its store full is dropped and sets overflow.
// Load bin: the serial shift-add area multiplier runs first, then insertion as above per copy.
// Run: each bin visited scans the rectangles, then an unplaced pass scans them once more;
// one record is held back so the final beat carries last, each beat then waits on out_stall.
// Reset (rst_n, async, active low) empties both stores and clears counts, overflow and control registers.
module shelf_rectangle_packer #(
    parameter int MAX_RECTS = 64,
    parameter int MAX_BINS  = 16,
    parameter int DIM_BITS  = 40
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [DIM_BITS-1:0] cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          req_type,
    input  logic [DIM_BITS-1:0] rect_width,
    input  logic [DIM_BITS-1:0] rect_height,
    input  logic [DIM_BITS-1:0] bin_length,
    input  logic [DIM_BITS-1:0] bin_width,
    input  logic [1:0]          bin_kind,
    input  logic [6:0]          copies,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          record_kind,
    output logic [5:0]          rect_index,
    output logic [5:0]          rect_copy,
    output logic [3:0]          bin_index,
    output logic [3:0]          bin_copy,
    output logic [DIM_BITS-1:0] pos_x,
    output logic [DIM_BITS-1:0] pos_y,
    output logic                overflow,
    output logic                last
);

    srp_pkg::cmd_t    cmd;
    srp_pkg::status_t st;

    srp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .st       (st),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    srp_dp #(
        .MAX_RECTS (MAX_RECTS),
        .MAX_BINS  (MAX_BINS),
        .DIM_BITS  (DIM_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_type    (req_type),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .bin_length  (bin_length),
        .bin_width   (bin_width),
        .bin_kind    (bin_kind),
        .copies      (copies),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .record_kind (record_kind),
        .rect_index  (rect_index),
        .rect_copy   (rect_copy),
        .bin_index   (bin_index),
        .bin_copy    (bin_copy),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .overflow    (overflow),
        .last        (last)
    );

    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && req_type == srp_pkg::REQ_RUN |=> in_stall)
        else $error("run beat did not start the sequencer");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> record_kind != 2'd3)
        else $error("illegal record kind");

    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_kind == srp_pkg::KIND_NONE |-> last)
        else $error("empty-store record without last");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid
            && $stable({record_kind, rect_index, rect_copy, bin_index, bin_copy,
                        pos_x, pos_y, overflow, last}))
        else $error("stalled beat changed");

endmodule

### hw/rtl/srp_ram.sv
`timescale 1ns / 1ps
module srp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/srp_ctrl.sv
`timescale 1ns / 1ps
module srp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  srp_pkg::status_t st,
    output srp_pkg::cmd_t    cmd,
    output logic             in_stall
);

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_MUL       = 14'b00000000000010,
        S_INS_START = 14'b00000000000100,
        S_SCAN      = 14'b00000000001000,
        S_CMP       = 14'b00000000010000,
        S_WRITE     = 14'b00000000100000,
        S_RUN_START = 14'b00000001000000,
        S_BIN_NEXT  = 14'b00000010000000,
        S_BIN_LOAD  = 14'b00000100000000,
        S_RECT_RD   = 14'b00001000000000,
        S_RECT_EVAL = 14'b00010000000000,
        S_UNP_RD    = 14'b00100000000000,
        S_UNP_EVAL  = 14'b01000000000000,
        S_FLUSH     = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (st.req)
                        srp_pkg::REQ_RECT:
                        begin
                            cmd.capture = 1'b1;
                            state_next = S_INS_START;
                        end
                        srp_pkg::REQ_BIN:
                        begin
                            cmd.capture = 1'b1;
                            cmd.mul_start = 1'b1;
                            state_next = S_MUL;
                        end
                        srp_pkg::REQ_RUN:
                        begin
                            state_next = S_RUN_START;
                        end
                        srp_pkg::REQ_CLEAR:
                        begin
                            cmd.clear_all = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL:
            begin
                if (!st.mul_busy)
                begin
                    state_next = S_INS_START;
                end
            end
            S_INS_START:
            begin
                if (st.copies_done)
                begin
                    cmd.def_inc = 1'b1;
                    state_next = S_IDLE;
                end
                else if (st.store_full)
                begin
                    cmd.ins_drop = 1'b1;
                end
                else
                begin
                    cmd.ins_begin = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (st.i_zero)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    cmd.ins_read = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (st.shift_cond)
                begin
                    cmd.ins_shift = 1'b1;
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.ins_write = 1'b1;
                state_next = S_INS_START;
            end
            S_RUN_START:
            begin
                if (st.n_zero)
                begin
                    cmd.emit_none = 1'b1;
                    state_next = S_FLUSH;
                end
                else
                begin
                    cmd.run_init = 1'b1;
                    state_next = S_BIN_NEXT;
                end
            end
            S_BIN_NEXT:
            begin
                if (st.bins_done)
                begin
                    cmd.unp_init = 1'b1;
                    state_next = S_UNP_RD;
                end
                else
                begin
                    cmd.bin_read = 1'b1;
                    state_next = S_BIN_LOAD;
                end
            end
            S_BIN_LOAD:
            begin
                cmd.bin_load = 1'b1;
                state_next = S_RECT_RD;
            end
            S_RECT_RD:
            begin
                if (st.q_done)
                begin
                    cmd.bin_next = 1'b1;
                    state_next = S_BIN_NEXT;
                end
                else
                begin
                    cmd.rect_read = 1'b1;
                    state_next = S_RECT_EVAL;
                end
            end
            S_RECT_EVAL:
            begin
                if (st.placed_q || !st.fit_y)
                begin
                    cmd.q_inc = 1'b1;
                    state_next = S_RECT_RD;
                end
                else if (!st.fit_x)
                begin
                    // open a new row and retry, unless the row is still empty
                    if (st.row_has)
                    begin
                        cmd.new_row = 1'b1;
                    end
                    else
                    begin
                        cmd.q_inc = 1'b1;
                        state_next = S_RECT_RD;
                    end
                end
                else if (st.slot_ok)
                begin
                    cmd.place = 1'b1;
                    state_next = S_RECT_RD;
                end
            end
            S_UNP_RD:
            begin
                if (st.q_done)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    cmd.rect_read = 1'b1;
                    state_next = S_UNP_EVAL;
                end
            end
            S_UNP_EVAL:
            begin
                if (st.placed_q)
                begin
                    cmd.q_inc = 1'b1;
                    state_next = S_UNP_RD;
                end
                else if (st.slot_ok)
                begin
                    cmd.emit_unplaced = 1'b1;
                    state_next = S_UNP_RD;
                end
            end
            S_FLUSH:
            begin
                if (st.out_free)
                begin
                    cmd.flush = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/srp_dp.sv
`timescale 1ns / 1ps
module srp_dp #(
    parameter int MAX_RECTS = 64,
    parameter int MAX_BINS  = 16,
    parameter int DIM_BITS  = 40
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  srp_pkg::cmd_t        cmd,
    output srp_pkg::status_t     st,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [DIM_BITS-1:0]  cfg_data,
    input  logic [1:0]           req_type,
    input  logic [DIM_BITS-1:0]  rect_width,
    input  logic [DIM_BITS-1:0]  rect_height,
    input  logic [DIM_BITS-1:0]  bin_length,
    input  logic [DIM_BITS-1:0]  bin_width,
    input  logic [1:0]           bin_kind,
    input  logic [6:0]           copies,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [1:0]           record_kind,
    output logic [5:0]           rect_index,
    output logic [5:0]           rect_copy,
    output logic [3:0]           bin_index,
    output logic [3:0]           bin_copy,
    output logic [DIM_BITS-1:0]  pos_x,
    output logic [DIM_BITS-1:0]  pos_y,
    output logic                 overflow,
    output logic                 last
);

    localparam int D    = DIM_BITS;
    localparam int PW   = D + 2;
    localparam int EW   = D + 3;
    localparam int AW   = 2 * D;
    localparam int RA_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int RC_W = $clog2(MAX_RECTS + 1);
    localparam int BA_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int BC_W = $clog2(MAX_BINS + 1);
    localparam int IW   = (RC_W > BC_W) ? RC_W : BC_W;
    localparam int MW   = $clog2(D + 1);
    localparam int RID  = srp_pkg::RID_W;
    localparam int BID  = srp_pkg::BID_W;
    localparam int RE_W = 2 * D + RID;
    localparam int BE_W = 2 * D + AW + BID;

    // configuration
    logic [D-1:0] spacing_reg, trim_reg;

    // load request
    logic         sel_bin_reg;
    logic [D-1:0] nw_reg, nh_reg, nl_reg, nbw_reg;
    logic [1:0]   kind_reg;
    logic [6:0]   copies_reg, c_reg;
    logic [5:0]   rect_defs_reg;
    logic [3:0]   bin_defs_reg;
    logic [RC_W-1:0] rect_count_reg;
    logic [BC_W-1:0] bin_count_reg;
    logic         overflow_reg;
    logic [IW-1:0] ins_i_reg;
    logic [IW-1:0] ins_im1;

    // area multiplier
    logic [AW-1:0] acc_reg, mcand_reg;
    logic [D-1:0]  mplier_reg;
    logic [MW-1:0] mcnt_reg;

    // packing run
    logic [MAX_RECTS-1:0] placed_reg;
    logic [RC_W-1:0] remaining_reg, q_reg;
    logic [BC_W-1:0] bi_reg;
    logic [D-1:0]    cl_reg, cw_reg, rh_reg;
    logic [BID-1:0]  cbid_reg;
    logic [PW-1:0]   x_reg, y_reg;
    logic            row_reg;

    // record buffers
    logic            pend_valid_reg;
    logic [1:0]      pend_kind_reg;
    logic [RID-1:0]  pend_rid_reg;
    logic [7:0]      pend_bid_reg;
    logic [D-1:0]    pend_x_reg, pend_y_reg;
    logic            pend_ovf_reg;
    logic            out_valid_reg;
    logic [1:0]      out_kind_reg;
    logic [RID-1:0]  out_rid_reg;
    logic [7:0]      out_bid_reg;
    logic [D-1:0]    out_x_reg, out_y_reg;
    logic            out_ovf_reg, out_last_reg;

    // memories
    logic            rram_we, rram_re, bram_we, bram_re;
    logic [RA_W-1:0] rram_waddr, rram_raddr;
    logic [BA_W-1:0] bram_waddr, bram_raddr;
    logic [RE_W-1:0] rram_wdata, rram_rdata;
    logic [BE_W-1:0] bram_wdata, bram_rdata;

    logic [D-1:0]    rd_w, rd_h;
    logic [RID-1:0]  rd_id;
    logic [D-1:0]    bd_l, bd_w;
    logic [AW-1:0]   bd_area;
    logic [BID-1:0]  bd_id;

    logic            emit, out_free, move_out;
    logic [1:0]      new_kind;
    logic [RID-1:0]  new_rid;
    logic [7:0]      new_bid;
    logic [D-1:0]    new_x, new_y;

    assign ins_im1 = ins_i_reg - IW'(1);

    assign {rd_w, rd_h, rd_id} = rram_rdata;
    assign {bd_l, bd_w, bd_area, bd_id} = bram_rdata;

    assign rram_we    = (cmd.ins_shift || cmd.ins_write) && !sel_bin_reg;
    assign rram_waddr = ins_i_reg[RA_W-1:0];
    assign rram_wdata = cmd.ins_shift ? rram_rdata
                                      : {nw_reg, nh_reg, rect_defs_reg, c_reg[5:0]};
    assign rram_re    = (cmd.ins_read && !sel_bin_reg) || cmd.rect_read;
    assign rram_raddr = cmd.ins_read ? ins_im1[RA_W-1:0] : q_reg[RA_W-1:0];

    assign bram_we    = (cmd.ins_shift || cmd.ins_write) && sel_bin_reg;
    assign bram_waddr = ins_i_reg[BA_W-1:0];
    assign bram_wdata = cmd.ins_shift ? bram_rdata
                                      : {nl_reg, nbw_reg, acc_reg, kind_reg, bin_defs_reg,
                                         c_reg[3:0]};
    assign bram_re    = (cmd.ins_read && sel_bin_reg) || cmd.bin_read;
    assign bram_raddr = cmd.ins_read ? ins_im1[BA_W-1:0] : bi_reg[BA_W-1:0];

    srp_ram #(.WIDTH(RE_W), .DEPTH(MAX_RECTS)) u_rect_ram (
        .clk   (clk),
        .we    (rram_we),
        .waddr (rram_waddr),
        .wdata (rram_wdata),
        .re    (rram_re),
        .raddr (rram_raddr),
        .rdata (rram_rdata)
    );

    srp_ram #(.WIDTH(BE_W), .DEPTH(MAX_BINS)) u_bin_ram (
        .clk   (clk),
        .we    (bram_we),
        .waddr (bram_waddr),
        .wdata (bram_wdata),
        .re    (bram_re),
        .raddr (bram_raddr),
        .rdata (bram_rdata)
    );

    // status
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        st = '0;
        st.req         = srp_pkg::req_t'(req_type);
        st.mul_busy    = (mcnt_reg != '0);
        st.copies_done = (c_reg == copies_reg);
        st.store_full  = sel_bin_reg ? (bin_count_reg == BC_W'(MAX_BINS))
                                     : (rect_count_reg == RC_W'(MAX_RECTS));
        st.i_zero      = (ins_i_reg == '0);
        // stable insertion: move the older entry down only if the new one sorts strictly ahead
        if (sel_bin_reg)
        begin
            st.shift_cond = (kind_reg > bd_id[BID-1 -: 2])
                         || ((kind_reg == bd_id[BID-1 -: 2]) && (acc_reg < bd_area));
        end
        else
        begin
            st.shift_cond = (rd_h < nh_reg);
        end
        st.n_zero    = (rect_count_reg == '0);
        st.bins_done = (bi_reg == bin_count_reg) || (remaining_reg == '0);
        st.q_done    = (q_reg == rect_count_reg);
        st.placed_q  = placed_reg[q_reg[RA_W-1:0]];
        st.fit_x     = (EW'(x_reg) + EW'(rd_w) + EW'(trim_reg)) <= EW'(cl_reg);
        st.fit_y     = (EW'(y_reg) + EW'(rd_h) + EW'(trim_reg)) <= EW'(cw_reg);
        st.row_has   = row_reg;
        st.slot_ok   = !pend_valid_reg || out_free;
        st.out_free  = out_free;
    end

    // new record
    assign emit = cmd.place || cmd.emit_unplaced || cmd.emit_none;

    always_comb
    begin
        new_kind = srp_pkg::KIND_NONE;
        new_rid  = '0;
        new_bid  = '0;
        new_x    = '0;
        new_y    = '0;
        if (cmd.place)
        begin
            new_kind = srp_pkg::KIND_PLACED;
            new_rid  = rd_id;
            new_bid  = cbid_reg[7:0];
            new_x    = x_reg[D-1:0];
            new_y    = y_reg[D-1:0];
        end
        else if (cmd.emit_unplaced)
        begin
            new_kind = srp_pkg::KIND_UNPLACED;
            new_rid  = rd_id;
        end
    end

    assign move_out = (emit && pend_valid_reg) || cmd.flush;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg    <= '0;
            trim_reg       <= '0;
            sel_bin_reg    <= 1'b0;
            c_reg          <= '0;
            copies_reg     <= '0;
            rect_defs_reg  <= '0;
            bin_defs_reg   <= '0;
            rect_count_reg <= '0;
            bin_count_reg  <= '0;
            overflow_reg   <= 1'b0;
            ins_i_reg      <= '0;
            mcnt_reg       <= '0;
            placed_reg     <= '0;
            remaining_reg  <= '0;
            q_reg          <= '0;
            bi_reg         <= '0;
            row_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    srp_pkg::CFG_SPACING: spacing_reg <= cfg_data;
                    srp_pkg::CFG_TRIM:    trim_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.capture)
            begin
                sel_bin_reg <= (srp_pkg::req_t'(req_type) == srp_pkg::REQ_BIN);
                copies_reg  <= copies;
                c_reg       <= '0;
            end
            if (cmd.mul_start)
            begin
                mcnt_reg <= MW'(D);
            end
            else if (mcnt_reg != '0)
            begin
                mcnt_reg <= mcnt_reg - MW'(1);
            end
            if (cmd.ins_begin)
            begin
                ins_i_reg <= sel_bin_reg ? IW'(bin_count_reg) : IW'(rect_count_reg);
            end
            if (cmd.ins_shift)
            begin
                ins_i_reg <= ins_im1;
            end
            if (cmd.ins_write)
            begin
                c_reg <= c_reg + 7'd1;
                if (sel_bin_reg)
                begin
                    bin_count_reg <= bin_count_reg + BC_W'(1);
                end
                else
                begin
                    rect_count_reg <= rect_count_reg + RC_W'(1);
                end
            end
            if (cmd.ins_drop)
            begin
                overflow_reg <= 1'b1;
                c_reg        <= c_reg + 7'd1;
            end
            if (cmd.def_inc)
            begin
                if (sel_bin_reg)
                begin
                    bin_defs_reg <= bin_defs_reg + 4'd1;
                end
                else
                begin
                    rect_defs_reg <= rect_defs_reg + 6'd1;
                end
            end
            if (cmd.clear_all)
            begin
                rect_count_reg <= '0;
                bin_count_reg  <= '0;
                overflow_reg   <= 1'b0;
                rect_defs_reg  <= '0;
                bin_defs_reg   <= '0;
            end
            if (cmd.run_init)
            begin
                placed_reg    <= '0;
                remaining_reg <= rect_count_reg;
                bi_reg        <= '0;
            end
            if (cmd.bin_load)
            begin
                q_reg   <= '0;
                row_reg <= 1'b0;
            end
            if (cmd.bin_next)
            begin
                bi_reg <= bi_reg + BC_W'(1);
            end
            if (cmd.unp_init)
            begin
                q_reg <= '0;
            end
            if (cmd.q_inc || cmd.emit_unplaced)
            begin
                q_reg <= q_reg + RC_W'(1);
            end
            if (cmd.new_row)
            begin
                row_reg <= 1'b0;
            end
            if (cmd.place)
            begin
                q_reg         <= q_reg + RC_W'(1);
                row_reg       <= 1'b1;
                remaining_reg <= remaining_reg - RC_W'(1);
                placed_reg[q_reg[RA_W-1:0]] <= 1'b1;
            end
            if (emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (move_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            nw_reg   <= rect_width;
            nh_reg   <= rect_height;
            nl_reg   <= bin_length;
            nbw_reg  <= bin_width;
            kind_reg <= bin_kind;
        end
        // shift-add area, one multiplier bit per cycle
        if (cmd.mul_start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= AW'(bin_length);
            mplier_reg <= bin_width;
        end
        else if (mcnt_reg != '0)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[AW-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[D-1:1]};
        end
        if (cmd.bin_load)
        begin
            cl_reg   <= bd_l;
            cw_reg   <= bd_w;
            cbid_reg <= bd_id;
            x_reg    <= PW'(trim_reg);
            y_reg    <= PW'(trim_reg);
            rh_reg   <= '0;
        end
        if (cmd.new_row)
        begin
            x_reg  <= PW'(trim_reg);
            y_reg  <= y_reg + PW'(rh_reg) + PW'(spacing_reg);
            rh_reg <= '0;
        end
        if (cmd.place)
        begin
            x_reg <= x_reg + PW'(rd_w) + PW'(spacing_reg);
            if (rd_h > rh_reg)
            begin
                rh_reg <= rd_h;
            end
        end
        if (emit)
        begin
            pend_kind_reg <= new_kind;
            pend_rid_reg  <= new_rid;
            pend_bid_reg  <= new_bid;
            pend_x_reg    <= new_x;
            pend_y_reg    <= new_y;
            pend_ovf_reg  <= overflow_reg;
        end
        if (move_out)
        begin
            out_kind_reg <= pend_kind_reg;
            out_rid_reg  <= pend_rid_reg;
            out_bid_reg  <= pend_bid_reg;
            out_x_reg    <= pend_x_reg;
            out_y_reg    <= pend_y_reg;
            out_ovf_reg  <= pend_ovf_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign out_valid   = out_valid_reg;
    assign record_kind = out_kind_reg;
    assign rect_index  = out_rid_reg[RID-1 -: 6];
    assign rect_copy   = out_rid_reg[5:0];
    assign bin_index   = out_bid_reg[7:4];
    assign bin_copy    = out_bid_reg[3:0];
    assign pos_x       = out_x_reg;
    assign pos_y       = out_y_reg;
    assign overflow    = out_ovf_reg;
    assign last        = out_last_reg;

endmodule
